@@ rtl/core/estop_pkg.sv @@
// estop_pkg: shared types and constants for the emergency-stop qualifier
`timescale 1ns / 1ps

package estop_pkg;

  typedef struct packed {
    logic        pin_level;
    logic [31:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic stop_active;
    logic debounced_level;
    logic latched;
  } result_t;

  localparam int unsigned ADDR_W = 4;

  localparam logic [ADDR_W-1:0] ADDR_ACTIVE_LEVEL  = 4'h0;
  localparam logic [ADDR_W-1:0] ADDR_DEBOUNCE_TIME = 4'h4;
  localparam logic [ADDR_W-1:0] ADDR_STOP_MODE     = 4'h8;

  // any other mode code behaves as require hold
  localparam logic [1:0] MODE_NORMALLY_CLOSED = 2'd0;
  localparam logic [1:0] MODE_NORMALLY_OPEN   = 2'd1;
  localparam logic [1:0] MODE_REQUIRE_HOLD    = 2'd2;

  localparam logic        RST_ACTIVE_LEVEL  = 1'b1;
  localparam logic [15:0] RST_DEBOUNCE_TIME = 16'd20;

endpackage

@@ rtl/core/estop_debounce_latch.sv @@
// estop_debounce_latch: debounced emergency-stop input with mode-dependent latch
//
//   channel  | direction | handshake                    | payload
//   ---------+-----------+------------------------------+---------------------
//   sample   | in        | sample_valid / sample_stall  | estop_pkg::sample_t
//   result   | out       | result_valid / result_stall  | estop_pkg::result_t
//   apb      | in / out  | psel penable pwrite pready   | paddr pwdata prdata
//
// one sample per cycle while the result side does not stall; each sample waits in the input
// register while the 32-bit timestamp difference and compare run, then lands in the result
// register.
// the debounce state updates as a sample moves into the result register.
// a stalled result holds the input register, which then stalls the sample side.
// synchronous reset clears state and configuration to its defaults.
`timescale 1ns / 1ps

module estop_debounce_latch (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sample_valid,
  output logic                           sample_stall,
  input  estop_pkg::sample_t             sample,
  output logic                           result_valid,
  input  logic                           result_stall,
  output estop_pkg::result_t             result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [estop_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  // configuration
  logic        active_level;
  logic [15:0] debounce_time;
  logic [1:0]  stop_mode;

  // debounce state
  logic        last_sample;
  logic [31:0] change_time;
  logic        accepted_level;
  logic        stop_flag;
  logic        latch_flag;

  // input register
  logic               s1_valid;
  estop_pkg::sample_t s1;

  logic        out_ready;
  logic        advance;
  logic        wr_en;

  logic        pressed;
  logic        last_sample_next;
  logic [31:0] change_time_next;
  logic [31:0] elapsed;
  logic        take;
  logic        accepted_level_next;
  logic        stop_flag_next;
  logic        latch_flag_next;
  logic        hold_mode;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_level  <= estop_pkg::RST_ACTIVE_LEVEL;
      debounce_time <= estop_pkg::RST_DEBOUNCE_TIME;
      stop_mode     <= estop_pkg::MODE_NORMALLY_CLOSED;
    end else if (wr_en) begin
      unique case (paddr)
        estop_pkg::ADDR_ACTIVE_LEVEL:  active_level  <= pwdata[0];
        estop_pkg::ADDR_DEBOUNCE_TIME: debounce_time <= pwdata[15:0];
        estop_pkg::ADDR_STOP_MODE:     stop_mode     <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      estop_pkg::ADDR_ACTIVE_LEVEL:  prdata = {31'd0, active_level};
      estop_pkg::ADDR_DEBOUNCE_TIME: prdata = {16'd0, debounce_time};
      estop_pkg::ADDR_STOP_MODE:     prdata = {30'd0, stop_mode};
      default:                       prdata = 32'd0;
    endcase
  end

  // pipeline handshake
  assign out_ready    = !result_valid || !result_stall;
  assign advance      = s1_valid && out_ready;
  assign sample_stall = s1_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!sample_stall) begin
      s1_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      s1 <= sample;
    end
  end

  // debounce and mode update for the sample in the input register
  always_comb begin
    pressed          = (s1.pin_level == active_level);
    last_sample_next = pressed;
    change_time_next = (pressed != last_sample) ? s1.now_ms : change_time;
    elapsed          = s1.now_ms - change_time_next;
    take             = (elapsed >= {16'd0, debounce_time}) && (accepted_level != pressed);
    hold_mode        = (stop_mode != estop_pkg::MODE_NORMALLY_CLOSED) &&
                       (stop_mode != estop_pkg::MODE_NORMALLY_OPEN);

    accepted_level_next = accepted_level;
    stop_flag_next      = stop_flag;
    latch_flag_next     = latch_flag;

    if (take) begin
      accepted_level_next = pressed;
      if (pressed) begin
        priority if (hold_mode) begin
          stop_flag_next = 1'b1;
        end else if (latch_flag) begin
          // press while latched releases the stop
          latch_flag_next = 1'b0;
          stop_flag_next  = 1'b0;
        end else begin
          stop_flag_next = 1'b1;
          if (stop_mode == estop_pkg::MODE_NORMALLY_OPEN) begin
            latch_flag_next = 1'b1;
          end
        end
      end else begin
        if (stop_mode != estop_pkg::MODE_NORMALLY_OPEN || !latch_flag) begin
          stop_flag_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample    <= 1'b0;
      change_time    <= 32'd0;
      accepted_level <= 1'b0;
      stop_flag      <= 1'b0;
      latch_flag     <= 1'b0;
    end else if (advance) begin
      last_sample    <= last_sample_next;
      change_time    <= change_time_next;
      accepted_level <= accepted_level_next;
      stop_flag      <= stop_flag_next;
      latch_flag     <= latch_flag_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_ready) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.stop_active     <= stop_flag_next;
      result.debounced_level <= accepted_level_next;
      result.latched         <= latch_flag_next;
    end
  end

  // the latch is only ever set in normally-open mode
  a_latch_mode: assert property (@(posedge clk) disable iff (rst)
    $rose(latch_flag) |-> $past(stop_mode) == estop_pkg::MODE_NORMALLY_OPEN)
    else $error("latch set outside normally-open mode");

  // debounced level moves only when a sample is processed
  a_level_on_advance: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(advance)) |-> $stable(accepted_level))
    else $error("debounced level changed without a sample");

  // a new result only comes from an occupied input register
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(s1_valid))
    else $error("result appeared without a sample");

endmodule

@@ verif/tb_estop_debounce_latch.sv @@
// tb_estop_debounce_latch: self-checking testbench for the debounced emergency-stop qualifier
`timescale 1ns / 1ps

module tb_estop_debounce_latch;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 300000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  estop_pkg::sample_t sample = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  estop_pkg::result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [estop_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  estop_debounce_latch dut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow configuration and debounce state
  logic        cfg_active;
  logic [15:0] cfg_debounce;
  logic [1:0]  cfg_mode;
  logic        sh_last;
  logic [31:0] sh_change;
  logic        sh_level;
  logic        sh_stop;
  logic        sh_latch;

  estop_pkg::result_t pending_flags[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_cnt = 0;
  int n_fail = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_writes = 0;
  int cycles = 0;
  logic [31:0] ts_cursor = '0;

  function automatic estop_pkg::result_t estop_step(input logic pin, input logic [31:0] ts);
    logic pressed;
    logic hold;
    logic [31:0] elapsed;
    estop_pkg::result_t r;
    pressed = (pin == cfg_active);
    if (pressed != sh_last) begin
      sh_last = pressed;
      sh_change = ts;
    end
    elapsed = ts - sh_change;
    if (elapsed >= {16'b0, cfg_debounce} && sh_level != sh_last) begin
      sh_level = sh_last;
      hold = (cfg_mode != estop_pkg::MODE_NORMALLY_CLOSED) &&
             (cfg_mode != estop_pkg::MODE_NORMALLY_OPEN);
      if (sh_level) begin
        if (hold) begin
          sh_stop = 1'b1;
        end else if (sh_latch) begin
          sh_latch = 1'b0;
          sh_stop = 1'b0;
        end else begin
          sh_stop = 1'b1;
          if (cfg_mode == estop_pkg::MODE_NORMALLY_OPEN) sh_latch = 1'b1;
        end
      end else if (cfg_mode == estop_pkg::MODE_NORMALLY_OPEN) begin
        if (!sh_latch) sh_stop = 1'b0;
      end else begin
        sh_stop = 1'b0;
      end
    end
    r.stop_active = sh_stop;
    r.debounced_level = sh_level;
    r.latched = sh_latch;
    return r;
  endfunction

  initial begin
    cfg_active = estop_pkg::RST_ACTIVE_LEVEL;
    cfg_debounce = estop_pkg::RST_DEBOUNCE_TIME;
    cfg_mode = estop_pkg::MODE_NORMALLY_CLOSED;
    sh_last = 1'b0;
    sh_change = '0;
    sh_level = 1'b0;
    sh_stop = 1'b0;
    sh_latch = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    estop_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_flags.size() == 0) begin
        $error("result transfer with nothing expected");
        n_fail++;
      end else begin
        want = pending_flags.pop_front();
        n_checked++;
        if (result.stop_active !== want.stop_active) begin
          $error("stop_active: expected %0b, actual %0b", want.stop_active, result.stop_active);
          n_fail++;
        end
        if (result.debounced_level !== want.debounced_level) begin
          $error("debounced_level: expected %0b, actual %0b",
                 want.debounced_level, result.debounced_level);
          n_fail++;
        end
        if (result.latched !== want.latched) begin
          $error("latched: expected %0b, actual %0b", want.latched, result.latched);
          n_fail++;
        end
      end
    end
  end

  // called and returns at a falling edge
  task automatic send_sample(input logic pin, input logic [31:0] ts);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample <= {pin, ts};
    do @(posedge clk); while (sample_stall);
    pending_flags.push_back(estop_step(pin, ts));
    n_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    sample_valid <= 1'b0;
    while (pending_flags.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic apb_write(input logic [estop_pkg::ADDR_W-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (addr)
      estop_pkg::ADDR_ACTIVE_LEVEL:  cfg_active = data[0];
      estop_pkg::ADDR_DEBOUNCE_TIME: cfg_debounce = data[15:0];
      estop_pkg::ADDR_STOP_MODE:     cfg_mode = data[1:0];
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_startup_normally_closed();
    // reset defaults: active high, 20 ms, normally closed
    send_sample(1'b1, 32'd0);
    send_sample(1'b1, 32'd20);
    send_sample(1'b0, 32'd25);
    send_sample(1'b0, 32'd44);
    send_sample(1'b0, 32'd45);
    wait_idle();
  endtask

  task automatic test_normally_open_latch();
    apb_write(estop_pkg::ADDR_DEBOUNCE_TIME, 32'd0);
    apb_write(estop_pkg::ADDR_STOP_MODE, {30'b0, estop_pkg::MODE_NORMALLY_OPEN});
    send_sample(1'b1, 32'hFFFF_FFFF);
    send_sample(1'b0, 32'd0);
    send_sample(1'b1, 32'd5);
    send_sample(1'b0, 32'd6);
    send_sample(1'b1, 32'd7);
    wait_idle();
  endtask

  task automatic test_mode_change_while_latched();
    apb_write(estop_pkg::ADDR_STOP_MODE, {30'b0, estop_pkg::MODE_NORMALLY_CLOSED});
    send_sample(1'b0, 32'd8);
    send_sample(1'b1, 32'd9);
    wait_idle();
  endtask

  task automatic test_hold_and_unused_mode();
    apb_write(estop_pkg::ADDR_STOP_MODE, {30'b0, estop_pkg::MODE_REQUIRE_HOLD});
    send_sample(1'b0, 32'd10);
    send_sample(1'b1, 32'd11);
    send_sample(1'b0, 32'd12);
    wait_idle();
    apb_write(estop_pkg::ADDR_STOP_MODE, {30'b0, MODE_UNUSED});
    send_sample(1'b1, 32'd13);
    send_sample(1'b0, 32'd14);
    wait_idle();
  endtask

  task automatic test_active_low();
    apb_write(estop_pkg::ADDR_ACTIVE_LEVEL, 32'd0);
    send_sample(1'b0, 32'd15);
    send_sample(1'b1, 32'd16);
    wait_idle();
  endtask

  task automatic test_long_debounce_backwards();
    apb_write(estop_pkg::ADDR_ACTIVE_LEVEL, 32'd1);
    apb_write(estop_pkg::ADDR_DEBOUNCE_TIME, 32'd65535);
    // timestamp stepping back wraps into a huge difference
    send_sample(1'b1, 32'd100);
    send_sample(1'b1, 32'd50);
    send_sample(1'b0, 32'd200);
    send_sample(1'b0, 32'd200 + 32'd65534);
    send_sample(1'b0, 32'd200 + 32'd65535);
    wait_idle();
  endtask

  task automatic pick_config();
    int r;
    logic [15:0] deb;
    logic [1:0] mode;
    r = $urandom_range(99);
    if (r < 10) deb = 16'd0;
    else if (r < 20) deb = 16'hFFFF;
    else if (r < 30) deb = 16'($urandom());
    else deb = 16'($urandom_range(1, 30));
    case ($urandom_range(3))
      0: mode = estop_pkg::MODE_NORMALLY_CLOSED;
      1: mode = estop_pkg::MODE_NORMALLY_OPEN;
      2: mode = estop_pkg::MODE_REQUIRE_HOLD;
      default: mode = MODE_UNUSED;
    endcase
    apb_write(estop_pkg::ADDR_ACTIVE_LEVEL, {31'b0, 1'($urandom_range(1))});
    apb_write(estop_pkg::ADDR_DEBOUNCE_TIME, {16'b0, deb});
    apb_write(estop_pkg::ADDR_STOP_MODE, {30'b0, mode});
  endtask

  // bouncy edges followed by a stable run, with some noise, cut-short runs and jumps near timestamp wraparound
  task automatic gen_samples(input int n);
    int sent;
    int kind;
    int step;
    int span;
    int elapsed;
    int d;
    logic target;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(99);
      if (kind < 10) begin
        send_sample(1'($urandom_range(1)), $urandom());
        sent++;
      end else if (kind < 14) begin
        ts_cursor = 32'hFFFF_FFFF - 32'($urandom_range(40));
      end else begin
        target = 1'($urandom_range(1));
        repeat ($urandom_range(4)) begin
          send_sample(1'($urandom_range(1)), ts_cursor);
          ts_cursor += 32'($urandom_range(3));
          sent++;
        end
        step = int'(cfg_debounce) / 4 + 1;
        span = int'(cfg_debounce) + $urandom_range(step);
        if ($urandom_range(99) < 20) span = int'(cfg_debounce) / 2;
        elapsed = 0;
        do begin
          send_sample(target, ts_cursor);
          d = $urandom_range(1, step);
          ts_cursor += 32'(d);
          elapsed += d;
          sent++;
        end while (elapsed <= span);
      end
    end
  endtask

  task automatic test_random_phase(input int s_pct, input int r_pct, input int n);
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    repeat (5) begin
      pick_config();
      gen_samples(n / 5);
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    apb_write(estop_pkg::ADDR_DEBOUNCE_TIME, 32'd2);
    hold_req = 60;
    gen_samples(25);
    wait_idle();
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_idle_pct = 38;
    recv_stall_pct = 61;
    test_startup_normally_closed();
    test_normally_open_latch();
    test_mode_change_while_latched();
    test_hold_and_unused_mode();
    test_active_low();
    test_long_debounce_backwards();
    test_random_phase(38, 61, 250);
    test_random_phase(61, 38, 250);
    test_random_phase(0, 0, 250);
    test_backpressure();
    wait_idle();
    repeat (4) @(negedge clk);
    $display("sent %0d samples over all stop modes and active levels, %0d register writes",
             n_sent, n_writes);
    $display("checked %0d results, %0d mismatches", n_checked, n_fail);
    if (n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
